FILE: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge out of reset
`define VN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication out of reset
`define VN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/vn_pkg.sv
// shared types and constants of the vector normaliser
package vn_pkg;
	localparam int COMP_W = 16;
	localparam int LEN_W = 16;
	localparam int SQ_W = 31;
	localparam int SUM_W = 32;
	localparam int SQRT_STAGES = SUM_W / 2;
	localparam int FRAC_BITS_DEF = 12;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_EPS = 1'b0;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		logic en;
		logic scale;
	} lane_ctl_t;
endpackage

FILE: design/vn_sqrt.sv
// pipelined floor square root, one result bit per stage
module vn_sqrt (
	input  logic                     clk,
	input  logic                     en,
	input  logic [vn_pkg::SUM_W-1:0] sum,
	output logic [vn_pkg::LEN_W-1:0] root
);
	import vn_pkg::*;

	logic [SUM_W-1:0] n_s [SQRT_STAGES];
	logic [SUM_W-1:0] r_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_st
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
		logic [SUM_W-1:0] n_in;
		logic [SUM_W-1:0] r_in;
		logic [SUM_W-1:0] trial;
		if (k == 0) begin : g_first
			assign n_in = sum;
			assign r_in = '0;
		end else begin : g_next
			assign n_in = n_s[k-1];
			assign r_in = r_s[k-1];
		end
		assign trial = r_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_in >= trial) begin
					n_s[k] <= n_in - trial;
					r_s[k] <= (r_in >> 1) + BIT;
				end else begin
					n_s[k] <= n_in;
					r_s[k] <= r_in >> 1;
				end
			end
		end
	end

	assign root = r_s[SQRT_STAGES-1][LEN_W-1:0];
endmodule

FILE: design/vn_div_lane.sv
// one component lane: pipelined restoring divide by the length, or the raw component when scale is clear
module vn_div_lane #(
	parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  vn_pkg::lane_ctl_t ctl,
	input  vn_pkg::comp_t     comp,
	input  vn_pkg::len_t      len,
	output vn_pkg::comp_t     res
);
	import vn_pkg::*;

	localparam int D = FRAC_BITS + 1;
	localparam int R_W = LEN_W + 1;

	logic [R_W-1:0] rem_s [D];
	logic [D-1:0]   q_s   [D];
	len_t           len_s [D];
	comp_t          raw_s [D];
	logic           neg_s [D];
	logic           scl_s [D];

	for (genvar k = 0; k < D; k++) begin : g_st
		logic [R_W-1:0] r_in;
		logic [R_W:0]   t;
		logic [D-1:0]   q_in;
		len_t           l_in;
		comp_t          raw_in;
		logic           neg_in;
		logic           scl_in;
		if (k == 0) begin : g_first
			assign raw_in = comp;
			assign neg_in = comp[COMP_W-1];
			assign r_in = comp[COMP_W-1] ? R_W'(-$signed({comp[COMP_W-1], comp}))
				: R_W'(comp);
			assign t = {1'b0, r_in};
			assign q_in = '0;
			assign l_in = len;
			assign scl_in = ctl.scale;
		end else begin : g_next
			assign raw_in = raw_s[k-1];
			assign neg_in = neg_s[k-1];
			assign r_in = rem_s[k-1];
			assign t = {r_in, 1'b0};
			assign q_in = q_s[k-1];
			assign l_in = len_s[k-1];
			assign scl_in = scl_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				raw_s[k] <= raw_in;
				neg_s[k] <= neg_in;
				len_s[k] <= l_in;
				scl_s[k] <= scl_in;
				if (t >= {2'b00, l_in}) begin
					rem_s[k] <= R_W'(t - {2'b00, l_in});
					q_s[k] <= {q_in[D-2:0], 1'b1};
				end else begin
					rem_s[k] <= R_W'(t);
					q_s[k] <= {q_in[D-2:0], 1'b0};
				end
			end
		end
	end

	logic [COMP_W-1:0] qx;
	assign qx = COMP_W'(q_s[D-1]);
	assign res = !scl_s[D-1] ? raw_s[D-1] : (neg_s[D-1] ? comp_t'(-qx) : comp_t'(qx));
endmodule

FILE: design/vector3_normalizer.sv
// vector normaliser top level: squaring lanes, root, divide lanes, output register
// in: x_in, y_in, z_in with in_valid / in_stall, accepted when valid and not stalled
// out: x_out, y_out, z_out, length, scaled with out_valid / out_stall
// one item enters per cycle while the output is not stalled
// an item passes these stages from accept to out_valid:
//   one squaring stage, one sum stage, sixteen root stages,
//   FRAC_BITS + 1 divide stages in each of the three component lanes,
//   and the output register
// throughput is one item per cycle while the output is not stalled, set by the fully pipelined root and dividers
// when out_stall is high with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped
// epsilon sits at byte address 0 of the apb port, pready is always high
// epsilon is to be written only while the pipeline is empty; the block does not enforce this
// reset empties the pipeline and clears epsilon to zero
// length above epsilon divides each component by it and sets scaled
`include "assert_macros.svh"
module vector3_normalizer #(
	parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  vn_pkg::comp_t              x_in,
	input  vn_pkg::comp_t              y_in,
	input  vn_pkg::comp_t              z_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output vn_pkg::comp_t              x_out,
	output vn_pkg::comp_t              y_out,
	output vn_pkg::comp_t              z_out,
	output vn_pkg::len_t               length,
	output logic                       scaled,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vn_pkg::PADDR_W-1:0] paddr,
	input  logic [vn_pkg::PDATA_W-1:0] pwdata,
	output logic [vn_pkg::PDATA_W-1:0] prdata,
	output logic                       pready
);
	import vn_pkg::*;

	localparam int D = FRAC_BITS + 1;
	localparam int LAT = 2 + SQRT_STAGES + D + 1;

	logic en;
	logic [LAT-1:0] v_q;
	len_t eps_q;

	assign en = !(v_q[LAT-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = v_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	assign pready = 1'b1;
	assign prdata = PDATA_W'(eps_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_EPS)) begin
			eps_q <= pwdata[LEN_W-1:0];
		end
	end

	comp_t in_c [3];
	comp_t c_s1 [3];
	logic [SQ_W-1:0] sq_s1 [3];
	comp_t c_s2 [3];
	logic [SUM_W-1:0] sum_s2;
	assign in_c[0] = x_in;
	assign in_c[1] = y_in;
	assign in_c[2] = z_in;

	for (genvar i = 0; i < 3; i++) begin : g_sq
		logic signed [2*COMP_W-1:0] p;
		assign p = in_c[i] * in_c[i];
		always_ff @(posedge clk) begin
			if (en) begin
				c_s1[i] <= in_c[i];
				sq_s1[i] <= p[SQ_W-1:0];
				c_s2[i] <= c_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
		end
	end

	len_t root;
	vn_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.sum  (sum_s2),
		.root (root)
	);

	comp_t cd_q [SQRT_STAGES][3];
	always_ff @(posedge clk) begin
		if (en) begin
			cd_q[0] <= c_s2;
			for (int k = 1; k < SQRT_STAGES; k++) begin
				cd_q[k] <= cd_q[k-1];
			end
		end
	end

	lane_ctl_t ctl;
	assign ctl.en = en;
	assign ctl.scale = root > eps_q;

	len_t ld_q [D];
	logic sd_q [D];
	always_ff @(posedge clk) begin
		if (en) begin
			ld_q[0] <= root;
			sd_q[0] <= ctl.scale;
			for (int k = 1; k < D; k++) begin
				ld_q[k] <= ld_q[k-1];
				sd_q[k] <= sd_q[k-1];
			end
		end
	end

	comp_t res [3];
	for (genvar i = 0; i < 3; i++) begin : g_lane
		vn_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk  (clk),
			.ctl  (ctl),
			.comp (cd_q[SQRT_STAGES-1][i]),
			.len  (root),
			.res  (res[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= res[0];
			y_out <= res[1];
			z_out <= res[2];
			length <= ld_q[D-1];
			scaled <= sd_q[D-1];
		end
	end

	`VN_ASSERT_IMP(a_scaled_nonzero, clk, arst_n, out_valid && scaled, length != '0, "scaled with zero length")
	`VN_ASSERT_IMP(a_scaled_eps, clk, arst_n, out_valid && scaled, length > eps_q, "scaled at or below epsilon")
	`VN_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(length), "stalled item lost")
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the vector normaliser: directed table, random vectors, epsilon sweep
`timescale 1ns / 1ps
module testbench;
	import vn_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LATENCY = FRAC + 20;
	localparam int N_RANDOM = 1400;
	localparam int N_DIRECTED = 16;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		len_t len;
		logic scl;
	} norm_res_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		logic known;
		norm_res_t res;
	} vec_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	comp_t x_in;
	comp_t y_in;
	comp_t z_in;
	logic out_valid;
	logic out_stall;
	comp_t x_out;
	comp_t y_out;
	comp_t z_out;
	len_t length;
	logic scaled;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	norm_res_t expected_q[$];
	len_t eps_model;
	int mismatches = 0;
	int results_seen = 0;
	int scaled_seen = 0;
	bit long_hold = 1'b0;
	vec_row_t vec_table[N_DIRECTED];

	vector3_normalizer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.x_in(x_in), .y_in(y_in), .z_in(z_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_out(x_out), .y_out(y_out), .z_out(z_out),
		.length(length), .scaled(scaled),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [31:0] floor_root(logic [31:0] n);
		logic [31:0] root;
		logic [31:0] bitv;
		root = 0;
		bitv = 32'h4000_0000;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic comp_t scale_comp(comp_t c, logic [31:0] len);
		logic [47:0] mag;
		logic [47:0] q;
		mag = (c < 0) ? 48'(-int'(c)) : 48'(int'(c));
		q = (mag << FRAC) / len;
		if (c < 0)
			q = -q;
		return q[15:0];
	endfunction

	function automatic norm_res_t normalise(comp_t x, comp_t y, comp_t z);
		norm_res_t r;
		logic [31:0] sum;
		logic [31:0] len;
		sum = 32'(int'(x) * int'(x)) + 32'(int'(y) * int'(y)) + 32'(int'(z) * int'(z));
		len = floor_root(sum);
		r.len = len[15:0];
		if (len > 32'(eps_model)) begin
			r.x = scale_comp(x, len);
			r.y = scale_comp(y, len);
			r.z = scale_comp(z, len);
			r.scl = 1'b1;
		end else begin
			r.x = x;
			r.y = y;
			r.z = z;
			r.scl = 1'b0;
		end
		return r;
	endfunction

	task automatic write_epsilon(len_t value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(REG_EPS) << 2;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		eps_model = value;
	endtask

	task automatic send_vector(comp_t x, comp_t y, comp_t z, bit known, norm_res_t res);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if ($urandom_range(0, 2) == 0)
			gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_in <= x;
		y_in <= y;
		z_in <= z;
		expected_q.push_back(known ? res : normalise(x, y, z));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic comp_t random_comp();
		case ($urandom_range(0, 5))
			0: return comp_t'($urandom_range(0, 65535));
			1: return comp_t'($urandom_range(0, 16) - 8);
			2: return comp_t'($urandom_range(0, 8192) - 4096);
			3: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
			default: return comp_t'($urandom_range(0, 1024) - 512);
		endcase
	endfunction

	// receiver: random stalls, one long hold while the sender keeps offering
	initial begin
		int wait_n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold && results_seen == 300) begin
				long_hold = 1'b1;
				out_stall <= 1'b1;
				repeat (3 * LATENCY) @(posedge clk);
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				wait_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
				if (wait_n != 0) begin
					out_stall <= 1'b1;
					repeat (wait_n) @(posedge clk);
				end
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		norm_res_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected item: x %0d y %0d z %0d len %0d scaled %0b",
						x_out, y_out, z_out, length, scaled);
			end else begin
				exp_r = expected_q.pop_front();
				if (exp_r.scl)
					scaled_seen <= scaled_seen + 1;
				if (exp_r.x !== x_out || exp_r.y !== y_out || exp_r.z !== z_out ||
						exp_r.len !== length || exp_r.scl !== scaled) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: exp %0d %0d %0d len %0d s %0b, got %0d %0d %0d len %0d s %0b",
							exp_r.x, exp_r.y, exp_r.z, exp_r.len, exp_r.scl,
							x_out, y_out, z_out, length, scaled);
				end
			end
		end
	end

	initial begin
		len_t eps_set[6];
		eps_model = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_in = '0;
		y_in = '0;
		z_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		eps_set = '{16'd0, 16'd65535, 16'd4096, 16'd100, 16'd56755, 16'd1};

		// zero vector, unit axes, extremes; known results where obvious
		vec_table[0] = '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0}};
		vec_table[1] = '{16'sd4096, 16'sd0, 16'sd0, 1'b1,
			'{16'sd4096, 16'sd0, 16'sd0, 16'd4096, 1'b1}};
		vec_table[2] = '{16'sd0, -16'sd4096, 16'sd0, 1'b1,
			'{16'sd0, -16'sd4096, 16'sd0, 16'd4096, 1'b1}};
		vec_table[3] = '{16'sd0, 16'sd0, 16'sh8000, 1'b1,
			'{16'sd0, 16'sd0, -16'sd4096, 16'd32768, 1'b1}};
		vec_table[4] = '{16'sh7fff, 16'sd0, 16'sd0, 1'b1,
			'{16'sd4096, 16'sd0, 16'sd0, 16'd32767, 1'b1}};
		vec_table[5] = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
			'{-16'sd2364, -16'sd2364, -16'sd2364, 16'd56755, 1'b1}};
		vec_table[6] = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0};
		vec_table[7] = '{16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, '0};
		vec_table[8] = '{16'sd1, 16'sd0, 16'sd0, 1'b1, '{16'sd4096, 16'sd0, 16'sd0, 16'd1, 1'b1}};
		vec_table[9] = '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0};
		vec_table[10] = '{16'sd3, 16'sd4, 16'sd0, 1'b0, '0};
		vec_table[11] = '{16'sh5555, -16'sh2aab, 16'sh1234, 1'b0, '0};
		vec_table[12] = '{-16'sd7, 16'sd2, 16'sd5, 1'b0, '0};
		vec_table[13] = '{16'sd1000, 16'sd2000, -16'sd3000, 1'b0, '0};
		vec_table[14] = '{16'sh00ff, 16'shff00, 16'sh0f0f, 1'b0, '0};
		vec_table[15] = '{-16'sd32767, 16'sd1, 16'sd0, 1'b0, '0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_vector(vec_table[i].x, vec_table[i].y, vec_table[i].z,
				vec_table[i].known, vec_table[i].res);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_epsilon(eps_set[p]);
			send_vector(16'sd0, 16'sd0, 16'sd0, 1'b0, '0);
			send_vector(16'sh7fff, 16'sh8000, 16'sd0, 1'b0, '0);
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				comp_t a;
				comp_t b;
				comp_t c;
				a = random_comp();
				b = random_comp();
				c = random_comp();
				send_vector(a, b, c, 1'b0, '0);
			end
			drain();
		end

		$display("covered %0d vectors, %0d of them normalised, over six epsilon settings",
			results_seen, scaled_seen);
		$display("long output hold applied: %0b", long_hold);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

FILE: vector3_normalizer.f
+incdir+design
design/vn_pkg.sv
design/vn_sqrt.sv
design/vn_div_lane.sv
design/vector3_normalizer.sv
tb/testbench.sv
